### hw/rtl/tqp_pkg.sv
// tone queue player package: request/result payload types, command types,
// sequencer states and timer constants
// no dependencies

package tqp_pkg;

  localparam int FREQ_W    = 20;
  localparam int MS_W      = 16;
  localparam int PERIOD_W  = 20;
  localparam int COMPARE_W = 19;

  // timer input clock, the dividend of every period computation
  localparam logic [PERIOD_W-1:0] TIMER_HZ = 20'd1000000;
  localparam int DIV_STEPS = PERIOD_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic REQ_PLAY = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [FREQ_W-1:0] tone_freq;
    logic [MS_W-1:0]   tone_ms;
  } in_item_t;

  typedef struct packed {
    logic                 accepted;
    logic                 pwm_enable;
    logic [PERIOD_W-1:0]  period_count;
    logic [COMPARE_W-1:0] compare_count;
    logic [MS_W-1:0]      remaining_ms;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_PLAY,
    CMD_NOP,
    CMD_TICK
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [FREQ_W-1:0] freq;
    logic [MS_W-1:0]   ms;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } cmdq_status_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [MS_W-1:0]   ms;
  } note_t;

  localparam int NOTE_W = $bits(note_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FETCH,
    ST_DIV,
    ST_RESP
  } back_state_t;

endpackage

### hw/rtl/tqp_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies

module tqp_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/tqp_front.sv
// tone queue player front: takes requests and sorts them into play,
// ignored and tick commands for the command queue
// depends on tqp_pkg

module tqp_front (
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tqp_pkg::in_item_t    in_data,
  input  tqp_pkg::cmdq_status_t q_status,
  output logic                 push,
  output tqp_pkg::cmd_t        push_cmd
);

  always_comb begin
    push_cmd.freq = in_data.tone_freq;
    push_cmd.ms   = in_data.tone_ms;
    if (in_data.req_type == tqp_pkg::REQ_TICK) begin
      push_cmd.kind = tqp_pkg::CMD_TICK;
    end else if ((in_data.tone_freq != '0) && (in_data.tone_ms != '0)) begin
      push_cmd.kind = tqp_pkg::CMD_PLAY;
    end else begin
      push_cmd.kind = tqp_pkg::CMD_NOP;
    end
  end

  assign in_ready = !q_status.full;
  assign push     = in_valid && in_ready;

endmodule

### hw/rtl/tqp_cmd_fifo.sv
// two entry command queue between front and back
// depends on tqp_pkg

module tqp_cmd_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  tqp_pkg::cmd_t         push_cmd,
  input  logic                  pop,
  output tqp_pkg::cmd_t         head,
  output tqp_pkg::cmdq_status_t status
);

  tqp_pkg::cmd_t entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign head             = entry_r[rd_ptr_r];
  assign status.full      = (count_r == 2'd2);
  assign status.not_empty = (count_r != 2'd0);

endmodule

### hw/rtl/tqp_back.sv
// tone queue player back: note queue, millisecond countdown, bit-serial
// period divider and result register
// depends on tqp_pkg and tqp_ram

module tqp_back #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tqp_pkg::cmd_t         head,
  input  tqp_pkg::cmdq_status_t q_status,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output tqp_pkg::out_item_t    out_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  tqp_pkg::back_state_t state_r, state_nxt;

  tqp_pkg::cmd_t                    cmd_r, cmd_nxt;
  logic [PTR_W-1:0]                 rptr_r, rptr_nxt;
  logic [PTR_W-1:0]                 wptr_r, wptr_nxt;
  logic                             playing_r, playing_nxt;
  logic [tqp_pkg::MS_W-1:0]         time_left_r, time_left_nxt;
  logic [tqp_pkg::PERIOD_W-1:0]     period_r, period_nxt;
  logic [tqp_pkg::COMPARE_W-1:0]    compare_r, compare_nxt;
  logic                             acc_r, acc_nxt;
  logic [tqp_pkg::FREQ_W-1:0]       div_r, div_nxt;
  logic [tqp_pkg::PERIOD_W-1:0]     dvd_r, dvd_nxt;
  logic [tqp_pkg::FREQ_W-1:0]       rem_r, rem_nxt;
  logic [tqp_pkg::PERIOD_W-1:0]     quo_r, quo_nxt;
  logic [tqp_pkg::DIV_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                             out_valid_r, out_valid_nxt;
  tqp_pkg::out_item_t               out_data_r, out_data_nxt;

  logic [PTR_W-1:0]             rptr_inc, wptr_inc;
  logic                         q_full, q_empty;
  logic [tqp_pkg::MS_W-1:0]     tl_dec;
  logic [tqp_pkg::FREQ_W:0]     trial;
  logic                         trial_ge;
  logic [tqp_pkg::FREQ_W:0]     trial_diff;
  logic                         div_last;
  logic                         resp_load;
  logic                         ram_we;
  tqp_pkg::note_t               ram_wdata;
  logic [tqp_pkg::NOTE_W-1:0]   ram_rdata;
  tqp_pkg::note_t               rd_note;

  assign rptr_inc = (rptr_r == PTR_LAST) ? '0 : rptr_r + PTR_W'(1);
  assign wptr_inc = (wptr_r == PTR_LAST) ? '0 : wptr_r + PTR_W'(1);
  assign q_full   = (wptr_inc == rptr_r);
  assign q_empty  = (rptr_r == wptr_r);
  assign tl_dec   = (time_left_r != '0) ? time_left_r - tqp_pkg::MS_W'(1) : time_left_r;

  assign trial      = {rem_r, dvd_r[tqp_pkg::PERIOD_W-1]};
  assign trial_ge   = (trial >= {1'b0, div_r});
  assign trial_diff = trial - {1'b0, div_r};
  assign div_last   = (cnt_r == tqp_pkg::DIV_CNT_W'(tqp_pkg::DIV_STEPS - 1));
  assign resp_load  = (state_r == tqp_pkg::ST_RESP) && (!out_valid_r || out_ready);

  assign rd_note = tqp_pkg::note_t'(ram_rdata);

  tqp_ram #(
    .WIDTH (tqp_pkg::NOTE_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_note_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (wptr_r),
    .wr_data (ram_wdata),
    .rd_addr (rptr_r),
    .rd_data (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tqp_pkg::ST_IDLE: begin
        if (q_status.not_empty) begin
          state_nxt = tqp_pkg::ST_EXEC;
        end
      end
      tqp_pkg::ST_EXEC: begin
        state_nxt = tqp_pkg::ST_RESP;
        case (cmd_r.kind)
          tqp_pkg::CMD_PLAY: begin
            if (!q_full && !playing_r) begin
              state_nxt = tqp_pkg::ST_DIV;
            end
          end
          tqp_pkg::CMD_TICK: begin
            if (playing_r && (tl_dec == '0) && !q_empty) begin
              state_nxt = tqp_pkg::ST_FETCH;
            end
          end
          default: state_nxt = tqp_pkg::ST_RESP;
        endcase
      end
      tqp_pkg::ST_FETCH: state_nxt = tqp_pkg::ST_DIV;
      tqp_pkg::ST_DIV: begin
        if (div_last) begin
          state_nxt = tqp_pkg::ST_RESP;
        end
      end
      tqp_pkg::ST_RESP: begin
        if (resp_load) begin
          state_nxt = tqp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tqp_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    pop           = 1'b0;
    ram_we        = 1'b0;
    ram_wdata     = {cmd_r.freq, cmd_r.ms};
    cmd_nxt       = cmd_r;
    rptr_nxt      = rptr_r;
    wptr_nxt      = wptr_r;
    playing_nxt   = playing_r;
    time_left_nxt = time_left_r;
    period_nxt    = period_r;
    compare_nxt   = compare_r;
    acc_nxt       = acc_r;
    div_nxt       = div_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    case (state_r)
      tqp_pkg::ST_IDLE: begin
        if (q_status.not_empty) begin
          pop     = 1'b1;
          cmd_nxt = head;
        end
      end
      tqp_pkg::ST_EXEC: begin
        acc_nxt = 1'b0;
        dvd_nxt = tqp_pkg::TIMER_HZ;
        rem_nxt = '0;
        quo_nxt = '0;
        cnt_nxt = '0;
        case (cmd_r.kind)
          tqp_pkg::CMD_PLAY: begin
            if (!q_full) begin
              ram_we   = 1'b1;
              wptr_nxt = wptr_inc;
              acc_nxt  = 1'b1;
              // idle means the queue is empty, so the new note starts now
              if (!playing_r) begin
                rptr_nxt      = rptr_inc;
                playing_nxt   = 1'b1;
                time_left_nxt = cmd_r.ms;
                div_nxt       = cmd_r.freq;
              end
            end
          end
          tqp_pkg::CMD_TICK: begin
            if (playing_r) begin
              time_left_nxt = tl_dec;
              if ((tl_dec == '0) && q_empty) begin
                playing_nxt = 1'b0;
              end
            end
          end
          default: acc_nxt = 1'b0;
        endcase
      end
      tqp_pkg::ST_FETCH: begin
        rptr_nxt      = rptr_inc;
        time_left_nxt = rd_note.ms;
        div_nxt       = rd_note.freq;
      end
      tqp_pkg::ST_DIV: begin
        dvd_nxt = {dvd_r[tqp_pkg::PERIOD_W-2:0], 1'b0};
        rem_nxt = trial_ge ? trial_diff[tqp_pkg::FREQ_W-1:0] : trial[tqp_pkg::FREQ_W-1:0];
        quo_nxt = {quo_r[tqp_pkg::PERIOD_W-2:0], trial_ge};
        cnt_nxt = cnt_r + tqp_pkg::DIV_CNT_W'(1);
        if (div_last) begin
          period_nxt  = quo_nxt;
          compare_nxt = quo_nxt[tqp_pkg::PERIOD_W-1:1];
        end
      end
      tqp_pkg::ST_RESP: begin
        if (resp_load) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.accepted      = acc_r;
          out_data_nxt.pwm_enable    = playing_r;
          out_data_nxt.period_count  = period_r;
          out_data_nxt.compare_count = compare_r;
          out_data_nxt.remaining_ms  = time_left_r;
        end
      end
      default: pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tqp_pkg::ST_IDLE;
      rptr_r      <= '0;
      wptr_r      <= '0;
      playing_r   <= 1'b0;
      time_left_r <= '0;
      period_r    <= '0;
      compare_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rptr_r      <= rptr_nxt;
      wptr_r      <= wptr_nxt;
      playing_r   <= playing_nxt;
      time_left_r <= time_left_nxt;
      period_r    <= period_nxt;
      compare_r   <= compare_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    acc_r      <= acc_nxt;
    div_r      <= div_nxt;
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // silent player has an empty note queue
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tqp_pkg::ST_IDLE && !playing_r) |-> (rptr_r == wptr_r))
    else $error("idle player with notes queued");

  // a fetch only follows when a queued note exists
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tqp_pkg::ST_FETCH) |-> (rptr_r != wptr_r))
    else $error("note fetch from empty queue");

  // queued notes never carry a zero frequency
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tqp_pkg::ST_DIV) |-> (div_r != '0))
    else $error("divide by zero frequency");

  // divider finishes after its last step and reports a sounding note
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tqp_pkg::ST_DIV && div_last) |=> (state_r == tqp_pkg::ST_RESP && playing_r))
    else $error("divider did not hand over to response");

endmodule

### hw/rtl/tone_queue_player.sv
// tone queue player top level: front, command queue and back
// depends on tqp_pkg, tqp_front, tqp_cmd_fifo, tqp_back, tqp_ram
//
//   channel   direction   handshake             payload
//   in_       request     in_valid / in_ready    tqp_pkg::in_item_t
//   out_      result      out_valid / out_ready  tqp_pkg::out_item_t
//
// one result per request, in order
// ignored requests, dropped requests and plain ticks pass through idle, exec and resp in the back
// a play request that starts a note also runs the 20 step bit-serial period divider, and a
// tick that starts the next queued note first fetches that note and then runs the divider
// synchronous active-low reset, no memory clearing pass
// the front keeps taking requests into a two entry command queue while a
// result waits on out_ready

module tone_queue_player #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tqp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tqp_pkg::out_item_t out_data
);

  tqp_pkg::cmdq_status_t q_status;
  tqp_pkg::cmd_t         push_cmd;
  tqp_pkg::cmd_t         head;
  logic                  push;
  logic                  pop;

  tqp_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_status (q_status),
    .push     (push),
    .push_cmd (push_cmd)
  );

  tqp_cmd_fifo u_cmd_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  tqp_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### dv/tb_tone_queue_player.sv
// testbench for tone_queue_player: drives play and tick requests through the
// valid/ready channels and checks every result against an in-bench note queue model
// depends on tqp_pkg and tone_queue_player
`timescale 1ns / 100ps

module tb_tone_queue_player;

  localparam int QDEPTH       = 8;
  localparam int LIMIT_CYCLES = 2000000;
  localparam int MAX_REPORTS  = 10;
  localparam int DRAIN_CYCLES = 100;
  localparam int PHASE_HALF   = 150;

  logic               clk      = 1'b0;
  logic               rst_n    = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  tqp_pkg::in_item_t  in_data  = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  tqp_pkg::out_item_t out_data;

  tqp_pkg::in_item_t  pending_reqs[$];
  tqp_pkg::out_item_t expected_status[$];
  tqp_pkg::out_item_t want_status;
  int unsigned issued_cnt    = 0;
  int unsigned taken_cnt     = 0;
  int unsigned mismatch_cnt  = 0;
  int unsigned cycle_cnt     = 0;
  int unsigned src_idle_pct  = 0;
  int unsigned snk_stall_pct = 0;

  // note queue model
  logic [tqp_pkg::FREQ_W-1:0]    note_freq [QDEPTH];
  logic [tqp_pkg::MS_W-1:0]      note_ms   [QDEPTH];
  int unsigned                   head_idx   = 0;
  int unsigned                   tail_idx   = 0;
  logic                          sounding   = 1'b0;
  logic [tqp_pkg::MS_W-1:0]      ms_left    = '0;
  logic [tqp_pkg::PERIOD_W-1:0]  cur_reload = '0;
  logic [tqp_pkg::COMPARE_W-1:0] cur_half   = '0;

  tone_queue_player #(
    .QUEUE_DEPTH(QDEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic start_queued_note();
    int unsigned slot;
    if (head_idx == tail_idx) begin
      sounding = 1'b0;
      return;
    end
    slot       = head_idx;
    head_idx   = (head_idx + 1) % QDEPTH;
    cur_reload = tqp_pkg::TIMER_HZ / note_freq[slot];
    cur_half   = cur_reload[tqp_pkg::PERIOD_W-1:1];
    ms_left    = note_ms[slot];
    sounding   = 1'b1;
  endtask

  task automatic predict_status(input tqp_pkg::in_item_t r);
    tqp_pkg::out_item_t res;
    int unsigned        nxt;
    res = '0;
    if (r.req_type == tqp_pkg::REQ_PLAY) begin
      if (r.tone_freq != '0 && r.tone_ms != '0) begin
        nxt = (tail_idx + 1) % QDEPTH;
        if (nxt != head_idx) begin
          note_freq[tail_idx] = r.tone_freq;
          note_ms[tail_idx]   = r.tone_ms;
          tail_idx            = nxt;
          res.accepted        = 1'b1;
          if (!sounding) start_queued_note();
        end
      end
    end else if (sounding) begin
      if (ms_left != '0) ms_left = ms_left - 1'b1;
      if (ms_left == '0) start_queued_note();
    end
    res.pwm_enable    = sounding;
    res.period_count  = cur_reload;
    res.compare_count = cur_half;
    res.remaining_ms  = ms_left;
    expected_status.push_back(res);
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_status(in_data);
        taken_cnt++;
      end
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= pending_reqs.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_status.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("unexpected result %p", out_data);
        end else begin
          want_status = expected_status.pop_front();
          if (out_data.accepted      !== want_status.accepted      ||
              out_data.pwm_enable    !== want_status.pwm_enable    ||
              out_data.period_count  !== want_status.period_count  ||
              out_data.compare_count !== want_status.compare_count ||
              out_data.remaining_ms  !== want_status.remaining_ms) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
              $display({"mismatch: expected acc=%0d en=%0d per=%0d cmp=%0d rem=%0d,",
                        " got acc=%0d en=%0d per=%0d cmp=%0d rem=%0d"},
                       want_status.accepted, want_status.pwm_enable,
                       want_status.period_count, want_status.compare_count,
                       want_status.remaining_ms, out_data.accepted,
                       out_data.pwm_enable, out_data.period_count,
                       out_data.compare_count, out_data.remaining_ms);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("tb_tone_queue_player failed");
      $finish;
    end
  end

  function automatic tqp_pkg::in_item_t make_req(input logic t,
                                                 input logic [tqp_pkg::FREQ_W-1:0] f,
                                                 input logic [tqp_pkg::MS_W-1:0] m);
    tqp_pkg::in_item_t r;
    r.req_type  = t;
    r.tone_freq = f;
    r.tone_ms   = m;
    return r;
  endfunction

  function automatic logic [tqp_pkg::FREQ_W-1:0] rand_freq();
    case ($urandom_range(3))
      0:       return 20'($urandom_range(64, 1));
      1:       return 20'($urandom_range(1000000, 1));
      2:       return 20'($urandom_range(20'hFFFFF, 1000001));
      default: return 20'($urandom_range(20'hFFFFF, 1));
    endcase
  endfunction

  // mostly ticks and short notes so the queue wanders between empty and full
  function automatic tqp_pkg::in_item_t rand_request();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 64)
      return make_req(tqp_pkg::REQ_TICK, 20'($urandom), 16'($urandom));
    if (sel < 88)
      return make_req(tqp_pkg::REQ_PLAY, rand_freq(),
                      16'(($urandom_range(99) < 97) ? $urandom_range(4, 1)
                                                    : $urandom_range(40, 1)));
    if (sel < 94)
      return make_req(tqp_pkg::REQ_PLAY, '0, 16'($urandom));
    return make_req(tqp_pkg::REQ_PLAY, 20'($urandom), '0);
  endfunction

  task automatic push_req(input tqp_pkg::in_item_t r);
    pending_reqs.push_back(r);
    issued_cnt++;
  endtask

  task automatic wait_settled();
    while (taken_cnt != issued_cnt || expected_status.size() != 0) @(negedge clk);
  endtask

  // with nothing in flight, fill every free slot and then send long notes that must drop
  task automatic fill_to_overflow();
    int unsigned room;
    wait_settled();
    room = QDEPTH - 1 - ((tail_idx + QDEPTH - head_idx) % QDEPTH) + (sounding ? 0 : 1);
    repeat (room)
      push_req(make_req(tqp_pkg::REQ_PLAY, rand_freq(), 16'($urandom_range(4, 1))));
    repeat (3)
      push_req(make_req(tqp_pkg::REQ_PLAY, rand_freq(), 16'($urandom_range(16'hFFFF, 1))));
  endtask

  int unsigned src_pcts [4] = '{0, 63, 0, 20};
  int unsigned snk_pcts [4] = '{0, 0, 63, 20};

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    push_req(make_req(tqp_pkg::REQ_TICK, '0, '0));
    push_req(make_req(tqp_pkg::REQ_PLAY, '0, 16'hFFFF));
    push_req(make_req(tqp_pkg::REQ_PLAY, 20'hFFFFF, '0));
    push_req(make_req(tqp_pkg::REQ_PLAY, 20'd1, 16'd1));
    push_req(make_req(tqp_pkg::REQ_PLAY, 20'd1000000, 16'd1));
    push_req(make_req(tqp_pkg::REQ_PLAY, 20'd1000001, 16'd2));
    push_req(make_req(tqp_pkg::REQ_PLAY, 20'hFFFFF, 16'd3));
    push_req(make_req(tqp_pkg::REQ_PLAY, 20'd3, 16'd1));
    push_req(make_req(tqp_pkg::REQ_PLAY, 20'd7, 16'd2));
    push_req(make_req(tqp_pkg::REQ_PLAY, 20'd999999, 16'd1));
    push_req(make_req(tqp_pkg::REQ_PLAY, 20'd2, 16'd1));
    push_req(make_req(tqp_pkg::REQ_PLAY, 20'hFFFFF, 16'hFFFF));
    push_req(make_req(tqp_pkg::REQ_PLAY, 20'd500, 16'd5));
    repeat (13) push_req(make_req(tqp_pkg::REQ_TICK, 20'hFFFFF, 16'hFFFF));

    for (int ph = 0; ph < 4; ph++) begin
      wait_settled();
      src_idle_pct  = src_pcts[ph];
      snk_stall_pct = snk_pcts[ph];
      repeat (PHASE_HALF) push_req(rand_request());
      fill_to_overflow();
      repeat (PHASE_HALF) push_req(rand_request());
    end

    wait_settled();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && expected_status.size() == 0)
      $display("tb_tone_queue_player passed");
    else
      $display("tb_tone_queue_player failed");
    $finish;
  end

endmodule
